### rtl/core/mfpd_pkg.sv
// mfpd_pkg: shared constants and types for the marker framed page deframer
// no dependencies; imported by marker_framed_page_deframer_top
package mfpd_pkg;

  // page geometry
  localparam int unsigned PAGE_BYTES = 32;
  localparam int unsigned OFS_W      = $clog2(PAGE_BYTES);
  localparam int unsigned WPOS_W     = OFS_W + 1;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned CIDX_W  = 3;

  // header length nibble mask
  localparam logic [BYTE_W-1:0] LEN_HI_MASK = 8'h0F;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_START_FIRST    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_SECOND   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_START_EITHER   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PATTERN_FIRST  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_PATTERN_SECOND = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_PATTERN_EITHER = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_END_MARKER     = 3'd6;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_START_FIRST    = 8'hA5;
  localparam logic [BYTE_W-1:0] RST_START_SECOND   = 8'h5A;
  localparam logic [BYTE_W-1:0] RST_START_EITHER   = 8'h99;
  localparam logic [BYTE_W-1:0] RST_PATTERN_FIRST  = 8'h0F;
  localparam logic [BYTE_W-1:0] RST_PATTERN_SECOND = 8'hF0;
  localparam logic [BYTE_W-1:0] RST_PATTERN_EITHER = 8'hA9;
  localparam logic [BYTE_W-1:0] RST_END_MARKER     = 8'hFF;

  // page write codes
  localparam logic [CODE_W-1:0] PW_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] PW_FIRST  = 2'd1;
  localparam logic [CODE_W-1:0] PW_APPEND = 2'd2;

  // frame event codes
  localparam logic [CODE_W-1:0] FE_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] FE_STARTED  = 2'd1;
  localparam logic [CODE_W-1:0] FE_COMPLETE = 2'd2;
  localparam logic [CODE_W-1:0] FE_DISCARD  = 2'd3;

  // one result item
  typedef struct packed {
    logic              store_valid;
    logic [OFS_W-1:0]  store_offset;
    logic [BYTE_W-1:0] store_data;
    logic [CODE_W-1:0] page_write;
    logic [CODE_W-1:0] frame_event;
    logic              lost_sync;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

endpackage

### rtl/core/marker_framed_page_deframer_top.sv
// marker_framed_page_deframer_top: byte deframer fsm with a registered result stage
// depends on mfpd_pkg for widths, register indexes and result codes
//
// usage
// - input channel (in_valid / in_stall / in_rx_byte) takes one decoded modem byte per item
// - result channel (out_valid / out_stall / out_*) gives exactly one result item per byte:
//   store write with page offset, page write flag, frame event, lost sync and the
//   latest header length
// - config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the marker
//   bytes; cfg_ready is always high, indexes beyond the end marker are ignored
// - each result is registered and leaves the cycle after its byte is taken; one item
//   per cycle while out_stall is low, set by the single fsm step before the result register
// - in_stall is raised only while a result waits in the result register and the
//   receiver stalls; the block holds its state and result until out_stall drops
// - reset (rst_n low, synchronous) restores the marker defaults, empties the result
//   register and puts the fsm back to hunting the first start byte
// - configuration is expected only while the block is idle
module marker_framed_page_deframer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mfpd_pkg::BYTE_W-1:0]  in_rx_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_store_valid,
  output logic [mfpd_pkg::OFS_W-1:0]   out_store_offset,
  output logic [mfpd_pkg::BYTE_W-1:0]  out_store_data,
  output logic [mfpd_pkg::CODE_W-1:0]  out_page_write,
  output logic [mfpd_pkg::CODE_W-1:0]  out_frame_event,
  output logic                         out_lost_sync,
  output logic [mfpd_pkg::LEN_W-1:0]   out_payload_length,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mfpd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mfpd_pkg::BYTE_W-1:0]  cfg_data
);
  import mfpd_pkg::*;

  // fsm phase codes
  localparam int unsigned PH_W = 4;
  localparam logic [PH_W-1:0] PH_START1 = 4'd0;
  localparam logic [PH_W-1:0] PH_START2 = 4'd1;
  localparam logic [PH_W-1:0] PH_NEXT   = 4'd2;
  localparam logic [PH_W-1:0] PH_PAT2   = 4'd3;
  localparam logic [PH_W-1:0] PH_HDR1   = 4'd4;
  localparam logic [PH_W-1:0] PH_HDR2   = 4'd5;
  localparam logic [PH_W-1:0] PH_META1  = 4'd6;
  localparam logic [PH_W-1:0] PH_META2  = 4'd7;
  localparam logic [PH_W-1:0] PH_FIRST  = 4'd8;
  localparam logic [PH_W-1:0] PH_DATA   = 4'd9;

  localparam logic [WPOS_W-1:0] PAGE_END = WPOS_W'(PAGE_BYTES);

  // marker registers
  logic [BYTE_W-1:0] start_first_r, start_second_r, start_either_r;
  logic [BYTE_W-1:0] pattern_first_r, pattern_second_r, pattern_either_r;
  logic [BYTE_W-1:0] end_marker_r;

  // fsm state
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [WPOS_W-1:0] wpos_r, wpos_nxt, wpos_inc;
  logic [LEN_W-1:0]  remain_r, remain_nxt, remain_dec;
  logic              block_done_r, block_done_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;

  // result register
  logic              out_valid_r;
  result_t           res_r, res_nxt;

  logic              in_take;
  logic              is_store;
  logic [BYTE_W-1:0] b;
  logic [CODE_W-1:0] pw_code;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign b         = in_rx_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r    <= RST_START_FIRST;
      start_second_r   <= RST_START_SECOND;
      start_either_r   <= RST_START_EITHER;
      pattern_first_r  <= RST_PATTERN_FIRST;
      pattern_second_r <= RST_PATTERN_SECOND;
      pattern_either_r <= RST_PATTERN_EITHER;
      end_marker_r     <= RST_END_MARKER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_FIRST:    start_first_r    <= cfg_data;
        CFG_START_SECOND:   start_second_r   <= cfg_data;
        CFG_START_EITHER:   start_either_r   <= cfg_data;
        CFG_PATTERN_FIRST:  pattern_first_r  <= cfg_data;
        CFG_PATTERN_SECOND: pattern_second_r <= cfg_data;
        CFG_PATTERN_EITHER: pattern_either_r <= cfg_data;
        CFG_END_MARKER:     end_marker_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // store write for header and payload phases
  assign is_store   = (phase_r >= PH_HDR1) && (phase_r <= PH_DATA);
  assign wpos_inc   = wpos_r + WPOS_W'(1);
  assign remain_dec = (remain_r != '0) ? remain_r - LEN_W'(1) : remain_r;
  assign pw_code    = (phase_r == PH_FIRST) ? PW_FIRST : PW_APPEND;

  // one fsm step per byte
  always_comb begin
    phase_nxt      = phase_r;
    wpos_nxt       = is_store ? wpos_inc : wpos_r;
    remain_nxt     = (is_store && phase_r >= PH_FIRST) ? remain_dec : remain_r;
    block_done_nxt = block_done_r;
    last_len_nxt   = last_len_r;

    res_nxt                = '0;
    res_nxt.store_valid    = is_store;
    res_nxt.store_offset   = is_store ? wpos_r[OFS_W-1:0] : '0;
    res_nxt.store_data     = is_store ? b : '0;
    res_nxt.page_write     = PW_NONE;
    res_nxt.frame_event    = FE_NONE;

    unique case (phase_r)
      PH_START1: begin
        if (b == start_first_r || b == start_either_r) phase_nxt = PH_START2;
      end
      PH_START2: begin
        if (b == start_second_r || b == start_either_r) begin
          phase_nxt           = PH_NEXT;
          block_done_nxt      = 1'b0;
          res_nxt.frame_event = FE_STARTED;
        end else begin
          phase_nxt = (b == start_first_r) ? PH_START2 : PH_START1;
        end
      end
      PH_NEXT: begin
        // pattern marker wins over an equal end marker
        if (b == pattern_first_r || b == pattern_either_r) begin
          phase_nxt = PH_PAT2;
        end else if (b == end_marker_r) begin
          phase_nxt = PH_START1;
          if (!block_done_r) begin
            wpos_nxt            = '0;
            remain_nxt          = '0;
            res_nxt.frame_event = FE_DISCARD;
          end else begin
            block_done_nxt      = 1'b0;
            res_nxt.frame_event = FE_COMPLETE;
          end
        end else begin
          phase_nxt         = PH_START1;
          res_nxt.lost_sync = 1'b1;
        end
      end
      PH_PAT2: begin
        if (b == pattern_second_r || b == pattern_either_r) begin
          phase_nxt = PH_HDR1;
          wpos_nxt  = '0;
        end else begin
          phase_nxt         = PH_START1;
          res_nxt.lost_sync = 1'b1;
        end
      end
      PH_HDR1: begin
        phase_nxt  = PH_HDR2;
        remain_nxt = {b[3:0] & LEN_HI_MASK[3:0], 8'h00};
      end
      PH_HDR2: begin
        phase_nxt    = PH_META1;
        remain_nxt   = remain_r + LEN_W'(b);
        last_len_nxt = remain_r + LEN_W'(b);
      end
      PH_META1: begin
        phase_nxt = PH_META2;
      end
      PH_META2: begin
        phase_nxt = (remain_r == '0) ? PH_NEXT : PH_FIRST;
      end
      PH_FIRST, PH_DATA: begin
        if (remain_dec == '0) begin
          res_nxt.page_write = pw_code;
          phase_nxt          = PH_NEXT;
          block_done_nxt     = 1'b1;
        end else if (wpos_inc >= PAGE_END) begin
          res_nxt.page_write = pw_code;
          phase_nxt          = PH_DATA;
          wpos_nxt           = '0;
        end
      end
      default: begin
        phase_nxt = PH_START1;
      end
    endcase

    res_nxt.payload_length = last_len_nxt;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START1;
      wpos_r       <= '0;
      remain_r     <= '0;
      block_done_r <= 1'b0;
      last_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r      <= phase_nxt;
        wpos_r       <= wpos_nxt;
        remain_r     <= remain_nxt;
        block_done_r <= block_done_nxt;
        last_len_r   <= last_len_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  // result ports
  assign out_valid          = out_valid_r;
  assign out_store_valid    = res_r.store_valid;
  assign out_store_offset   = res_r.store_offset;
  assign out_store_data     = res_r.store_data;
  assign out_page_write     = res_r.page_write;
  assign out_frame_event    = res_r.frame_event;
  assign out_lost_sync      = res_r.lost_sync;
  assign out_payload_length = res_r.payload_length;

  // checks
  a_page_write_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.page_write != PW_NONE) |-> res_r.store_valid)
    else $error("page write flagged without a store");

  a_event_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.frame_event != FE_NONE || res_r.lost_sync))
      |-> !res_r.store_valid)
    else $error("frame event or lost sync together with a store");

  a_sync_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.lost_sync) |-> (res_r.frame_event == FE_NONE))
    else $error("lost sync together with a frame event");

  a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= PAGE_END)
    else $error("write position beyond page end");

  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("accepted item gave no result");

endmodule

### tb/sv/tb_marker_framed_page_deframer_top.sv
// tb_marker_framed_page_deframer_top: self-checking bench for the marker framed page deframer
// predicts every result item from its own deframer model and checks each one as it leaves
// depends on mfpd_pkg and marker_framed_page_deframer_top
`timescale 1ns / 100ps

module tb_marker_framed_page_deframer_top;
  import mfpd_pkg::*;

  localparam int unsigned HDR_BYTES     = 4;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam logic [LEN_W-1:0]  LONG_LEN   = 12'd300;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = CFG_END_MARKER + 1'b1;

  // deframer phases as the bench tracks them
  typedef enum logic [3:0] {
    S_HUNT_A, S_HUNT_B, S_GAP, S_PAT_B, S_LEN_HI, S_LEN_LO,
    S_META_A, S_META_B, S_PAGE_FIRST, S_PAGE_MORE
  } dfr_state_e;

  // receiver stall styles
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_RHYTHM, RX_HEAVY} rx_style_e;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_stall  = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CIDX_W-1:0]   cfg_index  = '0;
  logic [BYTE_W-1:0]   cfg_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_store_valid;
  logic [OFS_W-1:0]    out_store_offset;
  logic [BYTE_W-1:0]   out_store_data;
  logic [CODE_W-1:0]   out_page_write;
  logic [CODE_W-1:0]   out_frame_event;
  logic                out_lost_sync;
  logic [LEN_W-1:0]    out_payload_length;
  logic                cfg_ready;

  marker_framed_page_deframer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_store_valid    (out_store_valid),
    .out_store_offset   (out_store_offset),
    .out_store_data     (out_store_data),
    .out_page_write     (out_page_write),
    .out_frame_event    (out_frame_event),
    .out_lost_sync      (out_lost_sync),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #6 clk = ~clk;

  // bench copy of the marker registers
  logic [BYTE_W-1:0] mk_start_a   = RST_START_FIRST;
  logic [BYTE_W-1:0] mk_start_b   = RST_START_SECOND;
  logic [BYTE_W-1:0] mk_start_alt = RST_START_EITHER;
  logic [BYTE_W-1:0] mk_pat_a     = RST_PATTERN_FIRST;
  logic [BYTE_W-1:0] mk_pat_b     = RST_PATTERN_SECOND;
  logic [BYTE_W-1:0] mk_pat_alt   = RST_PATTERN_EITHER;
  logic [BYTE_W-1:0] mk_end       = RST_END_MARKER;

  // bench copy of the deframer state
  dfr_state_e        dfr_st         = S_HUNT_A;
  logic [WPOS_W-1:0] wr_pos         = '0;
  logic [LEN_W-1:0]  left_to_store  = '0;
  logic              block_finished = 1'b0;
  logic [LEN_W-1:0]  hdr_length     = '0;

  result_t     store_item_q[$];
  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 4;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  rx_style_e   rx_style    = RX_FREE;
  int unsigned style_left  = 0;
  int unsigned rhythm      = 0;

  // advance the deframer by one byte and give the result item it causes
  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    // header and payload bytes go to the page buffer
    if (dfr_st >= S_LEN_HI) begin
      r.store_valid  = 1'b1;
      r.store_offset = wr_pos[OFS_W-1:0];
      r.store_data   = b;
      wr_pos = wr_pos + 1'b1;
      if (dfr_st >= S_PAGE_FIRST && left_to_store != 0)
        left_to_store = left_to_store - 1'b1;
    end
    case (dfr_st)
      S_HUNT_A: begin
        if (b == mk_start_a || b == mk_start_alt)
          dfr_st = S_HUNT_B;
      end
      S_HUNT_B: begin
        if (b == mk_start_b || b == mk_start_alt) begin
          dfr_st = S_GAP;
          block_finished = 1'b0;
          r.frame_event = FE_STARTED;
        end else begin
          dfr_st = (b == mk_start_a) ? S_HUNT_B : S_HUNT_A;
        end
      end
      S_GAP: begin
        // pattern marker beats an equal end marker
        if (b == mk_pat_a || b == mk_pat_alt) begin
          dfr_st = S_PAT_B;
        end else if (b == mk_end) begin
          dfr_st = S_HUNT_A;
          if (!block_finished) begin
            wr_pos = '0;
            left_to_store = '0;
            r.frame_event = FE_DISCARD;
          end else begin
            block_finished = 1'b0;
            r.frame_event = FE_COMPLETE;
          end
        end else begin
          dfr_st = S_HUNT_A;
          r.lost_sync = 1'b1;
        end
      end
      S_PAT_B: begin
        if (b == mk_pat_b || b == mk_pat_alt) begin
          dfr_st = S_LEN_HI;
          wr_pos = '0;
        end else begin
          dfr_st = S_HUNT_A;
          r.lost_sync = 1'b1;
        end
      end
      S_LEN_HI: begin
        dfr_st = S_LEN_LO;
        left_to_store = LEN_W'(b & LEN_HI_MASK) << 8;
      end
      S_LEN_LO: begin
        dfr_st = S_META_A;
        left_to_store = left_to_store + LEN_W'(b);
        hdr_length = left_to_store;
      end
      S_META_A: dfr_st = S_META_B;
      S_META_B: dfr_st = (left_to_store == 0) ? S_GAP : S_PAGE_FIRST;
      S_PAGE_FIRST, S_PAGE_MORE: begin
        // end of payload wins over a full page
        if (left_to_store == 0) begin
          r.page_write = (dfr_st == S_PAGE_FIRST) ? PW_FIRST : PW_APPEND;
          dfr_st = S_GAP;
          block_finished = 1'b1;
        end else if (wr_pos >= PAGE_BYTES) begin
          r.page_write = (dfr_st == S_PAGE_FIRST) ? PW_FIRST : PW_APPEND;
          dfr_st = S_PAGE_MORE;
          wr_pos = '0;
        end
      end
      default: dfr_st = S_HUNT_A;
    endcase
    r.payload_length = hdr_length;
    return r;
  endfunction

  // usually the normal marker byte, sometimes the alternate one
  function automatic logic [BYTE_W-1:0] either_of(input logic [BYTE_W-1:0] usual,
                                                  input logic [BYTE_W-1:0] alt);
    return ($urandom_range(0, 3) == 0) ? alt : usual;
  endfunction

  // block lengths, mostly short, often landing on page edges
  function automatic logic [LEN_W-1:0] block_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_W'(PAGE_BYTES - HDR_BYTES);
      2:       return LEN_W'(PAGE_BYTES * $urandom_range(2, 3) - HDR_BYTES);
      3, 4:    return LEN_W'($urandom_range(PAGE_BYTES - HDR_BYTES + 1, 100));
      default: return LEN_W'($urandom_range(1, PAGE_BYTES - HDR_BYTES - 1));
    endcase
  endfunction

  // offer one byte, with random gaps between bursts, and predict its result item
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    store_item_q.push_back(deframe_byte(b));
    items_sent++;
  endtask

  // stop sending and wait for every outstanding result item
  task automatic settle();
    in_valid <= 1'b0;
    while (store_item_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_valid stays up when another write follows
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                           input logic more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      CFG_START_FIRST:    mk_start_a   = val;
      CFG_START_SECOND:   mk_start_b   = val;
      CFG_START_EITHER:   mk_start_alt = val;
      CFG_PATTERN_FIRST:  mk_pat_a     = val;
      CFG_PATTERN_SECOND: mk_pat_b     = val;
      CFG_PATTERN_EITHER: mk_pat_alt   = val;
      CFG_END_MARKER:     mk_end       = val;
      default: ;
    endcase
  endtask

  task automatic program_markers(input logic [BYTE_W-1:0] sa, sb, salt, pa, pb, palt, e);
    settle();
    write_reg(CFG_START_FIRST,    sa,   1'b1);
    write_reg(CFG_START_SECOND,   sb,   1'b1);
    write_reg(CFG_START_EITHER,   salt, 1'b1);
    write_reg(CFG_PATTERN_FIRST,  pa,   1'b1);
    write_reg(CFG_PATTERN_SECOND, pb,   1'b1);
    write_reg(CFG_PATTERN_EITHER, palt, 1'b1);
    write_reg(CFG_END_MARKER,     e,    1'b0);
  endtask

  // a frame built from the current markers, now and then broken or left open
  task automatic send_frame();
    int unsigned      n_blocks;
    logic [LEN_W-1:0] len;
    if ($urandom_range(0, 9) == 0) push_byte(mk_start_a);
    push_byte(either_of(mk_start_a, mk_start_alt));
    push_byte(either_of(mk_start_b, mk_start_alt));
    n_blocks = $urandom_range(0, 3);
    repeat (n_blocks) begin
      push_byte(either_of(mk_pat_a, mk_pat_alt));
      // broken pattern marker
      if ($urandom_range(0, 24) == 0) begin
        push_byte(BYTE_W'($urandom));
        return;
      end
      push_byte(either_of(mk_pat_b, mk_pat_alt));
      len = block_length();
      push_byte({4'($urandom), len[LEN_W-1:8]});
      push_byte(len[7:0]);
      push_byte(BYTE_W'($urandom));
      push_byte(BYTE_W'($urandom));
      repeat (len) push_byte(BYTE_W'($urandom));
    end
    case ($urandom_range(0, 9))
      0:       push_byte(BYTE_W'($urandom));
      1:       ;
      default: push_byte(mk_end);
    endcase
  endtask

  // reset markers: every marker path and the fsm corners that need no full page
  task automatic test_directed_markers();
    // repeated first start byte keeps waiting for the second
    push_byte(RST_START_FIRST);
    push_byte(RST_START_FIRST);
    push_byte(RST_START_SECOND);
    // zero-length block, then an end marker with no finished block
    push_byte(RST_PATTERN_FIRST);
    push_byte(RST_PATTERN_SECOND);
    repeat (HDR_BYTES) push_byte(8'h00);
    push_byte(RST_END_MARKER);
    // alternate bytes at both marker positions, masked length nibble, one-byte block
    push_byte(RST_START_EITHER);
    push_byte(RST_START_EITHER);
    push_byte(RST_PATTERN_EITHER);
    push_byte(RST_PATTERN_EITHER);
    push_byte(8'hF0);
    push_byte(8'h01);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h55);
    push_byte(RST_END_MARKER);
    // broken second start byte
    push_byte(RST_START_FIRST);
    push_byte(8'h12);
    // broken pattern marker
    push_byte(RST_START_FIRST);
    push_byte(RST_START_SECOND);
    push_byte(RST_PATTERN_FIRST);
    push_byte(8'h33);
    // stray byte between blocks
    push_byte(RST_START_FIRST);
    push_byte(RST_START_SECOND);
    push_byte(8'h77);
  endtask

  // a long block with a masked high nibble, spanning many appended pages
  task automatic test_long_block();
    gap_max = 2;
    push_byte(mk_start_a);
    push_byte(mk_start_b);
    push_byte(mk_pat_a);
    push_byte(mk_pat_b);
    push_byte({4'hF, LONG_LEN[LEN_W-1:8]});
    push_byte(LONG_LEN[7:0]);
    push_byte(BYTE_W'($urandom));
    push_byte(BYTE_W'($urandom));
    repeat (LONG_LEN) push_byte(BYTE_W'($urandom));
    push_byte(mk_end);
    settle();
  endtask

  // random frames with noise between them under the current markers
  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    gap_max = $urandom_range(0, 6);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 5)) push_byte(BYTE_W'($urandom));
      send_frame();
    end
    settle();
  endtask

  // receiver holds off while the sender keeps offering, then the sender drains
  task automatic test_receiver_hold();
    settle();
    gap_max  = 0;
    hold_req = 1'b1;
    repeat (60) push_byte(BYTE_W'($urandom));
    settle();
  endtask

  // all-zero and all-one marker settings
  task automatic test_extreme_markers();
    program_markers('0, '0, '0, '0, '0, '0, '0);
    test_random_frames(RANDOM_ITEMS);
    program_markers('1, '1, '1, '1, '1, '1, '1);
    test_random_frames(RANDOM_ITEMS);
  endtask

  // colliding and random marker settings, plus a write past the last register
  task automatic test_random_markers();
    logic [BYTE_W-1:0] sa;
    logic [BYTE_W-1:0] pa;
    sa = BYTE_W'($urandom);
    pa = BYTE_W'($urandom);
    settle();
    write_reg(CFG_UNUSED, BYTE_W'($urandom), 1'b0);
    // start alternate equals start first, end marker equals pattern first
    program_markers(sa, BYTE_W'($urandom), sa, pa, BYTE_W'($urandom), BYTE_W'($urandom), pa);
    test_random_frames(RANDOM_ITEMS);
    repeat (2) begin
      program_markers(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      BYTE_W'($urandom));
      test_random_frames(RANDOM_ITEMS);
    end
  endtask

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      rhythm++;
      case (rx_style)
        RX_FREE:   out_stall <= 1'b0;
        RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_RHYTHM: out_stall <= ((rhythm % 5) < 2);
        default:   out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : check_store_items
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.store_valid    = out_store_valid;
      got.store_offset   = out_store_offset;
      got.store_data     = out_store_data;
      got.page_write     = out_page_write;
      got.frame_event    = out_frame_event;
      got.lost_sync      = out_lost_sync;
      got.payload_length = out_payload_length;
      if (store_item_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result item with nothing predicted", cycles);
      end else begin
        want = store_item_q.pop_front();
        if (got.store_valid !== want.store_valid || got.store_offset !== want.store_offset ||
            got.store_data !== want.store_data || got.page_write !== want.page_write ||
            got.frame_event !== want.frame_event || got.lost_sync !== want.lost_sync ||
            got.payload_length !== want.payload_length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"cycle %0d: expected sv=%0b ofs=%0d data=%h pw=%0d fe=%0d ls=%0b len=%0d,",
                      " got sv=%0b ofs=%0d data=%h pw=%0d fe=%0d ls=%0b len=%0d"}, cycles,
                     want.store_valid, want.store_offset, want.store_data, want.page_write,
                     want.frame_event, want.lost_sync, want.payload_length,
                     got.store_valid, got.store_offset, got.store_data, got.page_write,
                     got.frame_event, got.lost_sync, got.payload_length);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_marker_framed_page_deframer_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_markers();
    test_long_block();
    test_random_frames(RANDOM_ITEMS);
    test_receiver_hold();
    test_extreme_markers();
    test_random_markers();
    settle();
    if (mismatches == 0 && store_item_q.size() == 0) begin
      $display("tb_marker_framed_page_deframer_top: done, clean");
    end else begin
      $display("tb_marker_framed_page_deframer_top: done, errors");
    end
    $finish;
  end

endmodule
